// ===== src/soc_pkg.sv =====
// Shared types and constants for the segment occupancy checker.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package soc_pkg;

  // Map size and derived address widths.
  localparam int MAP_CELLS = 1048576;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int IDX_W     = 27;
  localparam logic [IDX_W-1:0] MAP_CELLS_W = IDX_W'(MAP_CELLS);

  // Field widths.
  localparam int COORD_W = 20;
  localparam int FRAC_W  = 8;
  localparam int CELL_W  = COORD_W - FRAC_W;
  localparam int DIM_W   = 13;
  localparam int THR_W   = 7;
  localparam int VAL_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Internal arithmetic widths.
  localparam int GRAD_W = 38;
  localparam int WIDE_W = 58;
  localparam int NUM_W  = 56;
  localparam int DEN_W  = 38;
  localparam int WALK_W = 13;
  localparam int Q16    = 16;

  // Bit-serial multiplier length.
  localparam int MUL_STEPS = COORD_W;
  localparam int ITER_W    = $clog2(MUL_STEPS);

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] RST_MAP_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RST_MAP_HEIGHT = 13'd1024;
  localparam logic [THR_W-1:0] RST_THRESHOLD  = 7'd20;

  // Cell value that marks unknown space.
  localparam logic [VAL_W-1:0] UNKNOWN_VAL = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mem_wr;
    logic grad_div;
    logic col_div;
    logic take_grad;
    logic mul_step;
    logic take_c;
    logic walk_setup;
    logic look;
    logic sel;
    logic advance;
  } soc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic vert;
    logic shallow;
    logic walk_empty;
    logic walk_last;
    logic div_done;
    logic cell_hit;
  } soc_status_t;

endpackage

`default_nettype wire

// ===== src/segment_occupancy_check.sv =====
// Top level of the segment occupancy checker: configuration registers and
// the controller/datapath pair. Uses soc_pkg, soc_ctrl and soc_datapath.
//
//   port group     direction  handshake               payload
//   item in        in         start_i && !busy_o      cmd_i, cell_index_i, cell_value_i, points
//   result out     out        done_o (one cycle)      blocked_o
//   config write   in         cfg_valid_i && ready    cfg_index_i, cfg_data_i
//
// A cell write passes through ST_WRITE, where the memory is written, and then
// strobes its result. A check runs the bit-serial divider for the gradient and
// the bit-serial multiplier for the intercept (a vertical segment skips both),
// divides once more for the first column of a steep segment, and then walks the
// cell pairs until a hit or the last pair, reading them through the single memory read port.
// Reset clears control state; map contents are undefined until written.
// The result strobe cannot be stalled; one item is in work at a time.
`default_nettype none

module segment_occupancy_check
  import soc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 cmd_i,
  input  wire logic [COORD_W-1:0]   cell_index_i,
  input  wire logic signed [VAL_W-1:0] cell_value_i,
  input  wire logic [COORD_W-1:0]   x_first_i,
  input  wire logic [COORD_W-1:0]   y_first_i,
  input  wire logic [COORD_W-1:0]   x_second_i,
  input  wire logic [COORD_W-1:0]   y_second_i,
  output logic                      done_o,
  output logic                      blocked_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i
);

  logic [DIM_W-1:0] map_width_q;
  logic [DIM_W-1:0] map_height_q;
  logic [THR_W-1:0] threshold_q;
  soc_cmd_t         dp_cmd;
  soc_status_t      dp_status;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= RST_MAP_WIDTH;
      map_height_q <= RST_MAP_HEIGHT;
      threshold_q  <= RST_THRESHOLD;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i[THR_W-1:0];
        default: begin
          map_width_q <= map_width_q;
        end
      endcase
    end
  end

  soc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .blocked_o   (blocked_o),
    .dp_cmd_o    (dp_cmd),
    .dp_status_i (dp_status)
  );

  soc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .cell_index_i (cell_index_i),
    .cell_value_i (cell_value_i),
    .x_first_i    (x_first_i),
    .y_first_i    (y_first_i),
    .x_second_i   (x_second_i),
    .y_second_i   (y_second_i),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .threshold_i  (threshold_q)
  );

endmodule

`default_nettype wire

// ===== src/soc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on soc_pkg for the operand widths.
`default_nettype none

module soc_divider
  import soc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [DEN_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next numerator bit into the partial remainder.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Control: count the steps and flag the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      if (fits) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DEN_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== src/soc_datapath.sv =====
// Datapath of the segment checker: point registers, gradient and intercept
// arithmetic, the cell walk and the occupancy memory. Uses soc_pkg, soc_divider.
`default_nettype none

module soc_datapath
  import soc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire soc_cmd_t           cmd_i,
  output soc_status_t             status_o,
  input  wire logic [COORD_W-1:0] cell_index_i,
  input  wire logic [VAL_W-1:0]   cell_value_i,
  input  wire logic [COORD_W-1:0] x_first_i,
  input  wire logic [COORD_W-1:0] y_first_i,
  input  wire logic [COORD_W-1:0] x_second_i,
  input  wire logic [COORD_W-1:0] y_second_i,
  input  wire logic [DIM_W-1:0]   map_width_i,
  input  wire logic [DIM_W-1:0]   map_height_i,
  input  wire logic [THR_W-1:0]   threshold_i
);

  typedef enum logic [1:0] {
    WALK_VERT,
    WALK_SHALLOW,
    WALK_STEEP
  } walk_mode_e;

  localparam logic signed [GRAD_W-1:0] ONE_G   = GRAD_W'(65536);
  localparam logic        [DEN_W:0]    ONE_REM = (DEN_W+1)'(65536);

  // Occupancy memory.
  logic [VAL_W-1:0] mem [MAP_CELLS];

  // Registers.
  logic [COORD_W-1:0]       px_q, py_q, qx_q, qy_q;
  logic [COORD_W-1:0]       wr_idx_q;
  logic [VAL_W-1:0]         wr_val_q;
  logic                     neg_q;
  logic signed [GRAD_W-1:0] grad_q;
  logic                     shallow_q;
  logic signed [WIDE_W-1:0] mcand_q;
  logic [COORD_W-1:0]       mplier_q;
  logic signed [WIDE_W-1:0] acc_q;
  logic signed [WIDE_W-1:0] c_q;
  walk_mode_e               mode_q;
  logic                     up_q;
  logic [WALK_W-1:0]        i_q;
  logic [WALK_W-1:0]        cnt_q;
  logic signed [WIDE_W-1:0] wv_q;
  logic [DEN_W-1:0]         rem_q;
  logic [DEN_W-1:0]         gabs_q;
  logic [VAL_W-1:0]         rdata_q;
  logic                     outside_q;

  // Combinational signals.
  logic [CELL_W-1:0]        pcol, prow, qcol, qrow;
  logic                     up_d;
  logic [COORD_W-1:0]       dx;
  logic signed [COORD_W:0]  dy;
  logic [COORD_W-1:0]       dy_abs;
  logic signed [WIDE_W-1:0] prow_w;
  logic signed [WIDE_W-1:0] a0;
  logic [WIDE_W-1:0]        a0_abs;
  logic [DEN_W-1:0]         gabs;
  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [NUM_W-1:0]         quo;
  logic [DEN_W-1:0]         rem;
  logic signed [GRAD_W-1:0] gq;
  logic signed [GRAD_W-1:0] grad_d;
  logic                     shallow_d;
  logic signed [WIDE_W-1:0] qs;
  logic signed [WIDE_W-1:0] floor_q;
  logic [DEN_W-1:0]         floor_r;
  logic [DEN_W:0]           rem_step;
  logic signed [WIDE_W-1:0] oc;
  logic [WALK_W-1:0]        axis;
  logic signed [WIDE_W-1:0] axis_w;
  logic signed [WIDE_W-1:0] col, row;
  logic [IDX_W-1:0]         idx;
  logic                     outside;
  logic [IDX_W-1:0]         wr_idx_w;

  // End point cells.
  assign pcol = px_q[COORD_W-1:FRAC_W];
  assign prow = py_q[COORD_W-1:FRAC_W];
  assign qcol = qx_q[COORD_W-1:FRAC_W];
  assign qrow = qy_q[COORD_W-1:FRAC_W];
  assign up_d = qrow >= prow;

  // Gradient operands: magnitudes for the divider.
  assign dx     = qx_q - px_q;
  assign dy     = $signed({1'b0, qy_q}) - $signed({1'b0, py_q});
  assign dy_abs = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);

  // First steep numerator, oriented so it grows by one row per step.
  assign prow_w = $signed(WIDE_W'(prow));
  assign a0     = up_d ? (((prow_w + 1) <<< Q16) - c_q) : (c_q - (prow_w <<< Q16));
  assign a0_abs = a0[WIDE_W-1] ? WIDE_W'(-a0) : WIDE_W'(a0);
  assign gabs   = grad_q[GRAD_W-1] ? DEN_W'(-grad_q) : DEN_W'(grad_q);

  // Shared divider: gradient first, then the first steep column.
  assign div_start = cmd_i.grad_div | cmd_i.col_div;
  assign div_num   = cmd_i.col_div ? a0_abs[NUM_W-1:0] : NUM_W'({dy_abs[COORD_W-1:0], 16'h0});
  assign div_den   = cmd_i.col_div ? gabs : DEN_W'(dx);

  soc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  // Gradient truncated toward zero and the walk kind it selects.
  assign gq        = $signed(quo[GRAD_W-1:0]);
  assign grad_d    = neg_q ? -gq : gq;
  assign shallow_d = up_d ? (grad_d < ONE_G) : (grad_d > -ONE_G);

  // Floor quotient and remainder of the first steep column.
  assign qs      = $signed(WIDE_W'(quo));
  assign floor_q = (neg_q && rem != '0) ? (-qs - 1) : (neg_q ? -qs : qs);
  assign floor_r = (neg_q && rem != '0) ? (gabs - rem) : (neg_q ? '0 : rem);
  assign rem_step = {1'b0, rem_q} + ONE_REM;

  // Cell of the current pair.
  assign oc     = (mode_q == WALK_SHALLOW) ? (wv_q >>> Q16) : wv_q;
  assign axis   = cmd_i.sel ? i_q : (i_q - 1'b1);
  assign axis_w = $signed(WIDE_W'(axis));
  assign col    = (mode_q == WALK_SHALLOW) ? axis_w : oc;
  assign row    = (mode_q == WALK_SHALLOW) ? oc : axis_w;
  assign idx    = IDX_W'(row[DIM_W-1:0]) * IDX_W'(map_width_i) + IDX_W'(col[DIM_W-1:0]);
  assign outside = col[WIDE_W-1] || row[WIDE_W-1]
                || (col >= $signed(WIDE_W'(map_width_i)))
                || (row >= $signed(WIDE_W'(map_height_i)))
                || (idx >= MAP_CELLS_W);

  assign wr_idx_w = IDX_W'(wr_idx_q);

  // Item capture with the points ordered by x.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wr_idx_q <= cell_index_i;
      wr_val_q <= cell_value_i;
      if (x_first_i > x_second_i) begin
        px_q <= x_second_i;
        py_q <= y_second_i;
        qx_q <= x_first_i;
        qy_q <= y_first_i;
      end else begin
        px_q <= x_first_i;
        py_q <= y_first_i;
        qx_q <= x_second_i;
        qy_q <= y_second_i;
      end
    end
  end

  // Gradient, bit-serial product and intercept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.grad_div) begin
      neg_q <= dy[COORD_W];
    end else if (cmd_i.col_div) begin
      neg_q <= a0[WIDE_W-1];
    end
    if (cmd_i.take_grad) begin
      grad_q    <= grad_d;
      shallow_q <= shallow_d;
      mcand_q   <= {{(WIDE_W-GRAD_W){grad_d[GRAD_W-1]}}, grad_d};
      mplier_q  <= shallow_d ? COORD_W'(qx_q[FRAC_W-1:0]) : qx_q;
      acc_q     <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
    if (cmd_i.take_c) begin
      c_q <= ($signed(WIDE_W'(qy_q)) <<< FRAC_W) - (acc_q >>> FRAC_W);
    end
  end

  // Walk registers: axis index, pairs left and the other coordinate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.walk_setup) begin
      if (px_q == qx_q || !shallow_q) begin
        cnt_q <= up_d ? (WALK_W'(qrow) - WALK_W'(prow)) : (WALK_W'(prow) - WALK_W'(qrow));
      end else begin
        cnt_q <= WALK_W'(qcol) - WALK_W'(pcol);
      end
    end else if (cmd_i.advance) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_setup) begin
      if (px_q == qx_q) begin
        mode_q <= WALK_VERT;
        up_q   <= up_d;
        i_q    <= up_d ? (WALK_W'(prow) + 1'b1) : WALK_W'(prow);
        wv_q   <= $signed(WIDE_W'(pcol));
      end else if (shallow_q) begin
        // Shallow pairs are taken from the far column back toward the near one.
        mode_q <= WALK_SHALLOW;
        up_q   <= 1'b0;
        i_q    <= WALK_W'(qcol);
        wv_q   <= c_q;
      end else begin
        mode_q <= WALK_STEEP;
        up_q   <= up_d;
        i_q    <= up_d ? (WALK_W'(prow) + 1'b1) : WALK_W'(prow);
        wv_q   <= floor_q;
        rem_q  <= floor_r;
        gabs_q <= gabs;
      end
    end else if (cmd_i.advance) begin
      i_q <= up_q ? (i_q + 1'b1) : (i_q - 1'b1);
      case (mode_q)
        WALK_SHALLOW: begin
          wv_q <= wv_q - {{(WIDE_W-GRAD_W){grad_q[GRAD_W-1]}}, grad_q};
        end
        WALK_STEEP: begin
          // The numerator grows by one row; at most one carry into the column.
          if (rem_step >= {1'b0, gabs_q}) begin
            rem_q <= DEN_W'(rem_step - {1'b0, gabs_q});
            wv_q  <= wv_q + 1;
          end else begin
            rem_q <= rem_step[DEN_W-1:0];
          end
        end
        default: begin
          wv_q <= wv_q;
        end
      endcase
    end
  end

  // Occupancy memory: cell writes and registered lookups.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && wr_idx_w < MAP_CELLS_W) begin
      mem[wr_idx_w[ADDR_W-1:0]] <= wr_val_q;
    end
    if (cmd_i.look) begin
      rdata_q <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q <= 1'b0;
    end else if (cmd_i.look) begin
      outside_q <= outside;
    end
  end

  // Status back to the controller.
  assign status_o.vert       = px_q == qx_q;
  assign status_o.shallow    = shallow_q;
  assign status_o.walk_empty = cnt_q == '0;
  assign status_o.walk_last  = cnt_q == WALK_W'(1);
  assign status_o.div_done   = div_done;
  assign status_o.cell_hit   = outside_q
                            || ($signed(rdata_q) > $signed({1'b0, threshold_i}))
                            || (rdata_q == UNKNOWN_VAL);

endmodule

`default_nettype wire

// ===== src/soc_ctrl.sv =====
// Controller state machine of the segment checker: sequences the datapath
// and drives the result strobe. Uses soc_pkg for the command and status types.
`default_nettype none

module soc_ctrl
  import soc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        cmd_i,
  output logic             busy_o,
  output logic             done_o,
  output logic             blocked_o,
  output soc_cmd_t         dp_cmd_o,
  input  wire soc_status_t dp_status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PREP,
    ST_GDIV,
    ST_MUL,
    ST_CONST,
    ST_BRANCH,
    ST_CDIV,
    ST_WALK,
    ST_LOOK0,
    ST_EVAL0,
    ST_LOOK1,
    ST_EVAL1
  } state_e;

  state_e            state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              done_q, done_d;
  logic              blocked_q, blocked_d;

  // Next state, datapath commands and result.
  always_comb begin
    state_d   = state_q;
    iter_d    = iter_q;
    done_d    = 1'b0;
    blocked_d = blocked_q;
    dp_cmd_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          dp_cmd_o.load = 1'b1;
          state_d = (cmd_i == CMD_WRITE) ? ST_WRITE : ST_PREP;
        end
      end
      ST_WRITE: begin
        dp_cmd_o.mem_wr = 1'b1;
        done_d    = 1'b1;
        blocked_d = 1'b0;
        state_d   = ST_IDLE;
      end
      ST_PREP: begin
        if (dp_status_i.vert) begin
          dp_cmd_o.walk_setup = 1'b1;
          state_d = ST_WALK;
        end else begin
          dp_cmd_o.grad_div = 1'b1;
          state_d = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (dp_status_i.div_done) begin
          dp_cmd_o.take_grad = 1'b1;
          iter_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        dp_cmd_o.mul_step = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(MUL_STEPS - 1)) begin
          state_d = ST_CONST;
        end
      end
      ST_CONST: begin
        dp_cmd_o.take_c = 1'b1;
        state_d = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (dp_status_i.shallow) begin
          dp_cmd_o.walk_setup = 1'b1;
          state_d = ST_WALK;
        end else begin
          dp_cmd_o.col_div = 1'b1;
          state_d = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (dp_status_i.div_done) begin
          dp_cmd_o.walk_setup = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        // A walk with no pairs reports clear.
        if (dp_status_i.walk_empty) begin
          done_d    = 1'b1;
          blocked_d = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_LOOK0;
        end
      end
      ST_LOOK0: begin
        dp_cmd_o.look = 1'b1;
        dp_cmd_o.sel  = 1'b0;
        state_d = ST_EVAL0;
      end
      ST_EVAL0: begin
        if (dp_status_i.cell_hit) begin
          done_d    = 1'b1;
          blocked_d = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_LOOK1;
        end
      end
      ST_LOOK1: begin
        dp_cmd_o.look = 1'b1;
        dp_cmd_o.sel  = 1'b1;
        state_d = ST_EVAL1;
      end
      ST_EVAL1: begin
        if (dp_status_i.cell_hit) begin
          done_d    = 1'b1;
          blocked_d = 1'b1;
          state_d   = ST_IDLE;
        end else if (dp_status_i.walk_last) begin
          done_d    = 1'b1;
          blocked_d = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          dp_cmd_o.advance = 1'b1;
          state_d = ST_LOOK0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iter_q    <= '0;
      done_q    <= 1'b0;
      blocked_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iter_q    <= iter_d;
      done_q    <= done_d;
      blocked_q <= blocked_d;
    end
  end

  assign busy_o    = state_q != ST_IDLE;
  assign done_o    = done_q;
  assign blocked_o = blocked_q;

endmodule

`default_nettype wire
